>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers shared by the rtl files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define LAG_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition must never be seen at a clock edge outside reset
`define LAG_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

>>> rtl/lag_pkg.sv
// ----------------------------------------------------------------------------
// lag_pkg
// shared types and constants of the life automaton generation block
// ----------------------------------------------------------------------------
package lag_pkg;

  // board limits
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_AW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  // request and configuration field widths
  localparam int REQ_W   = 2;
  localparam int COORD_W = 6;
  localparam int CFG_W   = 7;
  localparam int CFG_IW  = 1;

  // width that holds a configured or clamped dimension
  localparam int ROWS_CW = $clog2(MAX_ROWS + 1);
  localparam int COLS_CW = $clog2(MAX_COLS + 1);
  localparam int DIM_A   = (ROWS_CW > COLS_CW) ? ROWS_CW : COLS_CW;
  localparam int DIM_W   = (DIM_A > CFG_W) ? DIM_A : CFG_W;

  // register reset values
  localparam logic [CFG_W-1:0] ROWS_RESET = 7'd64;
  localparam logic [CFG_W-1:0] COLS_RESET = 7'd64;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_TICK  = 2'd2
  } req_e;

  // configuration register indexes
  typedef enum logic [CFG_IW-1:0] {
    CFG_BOARD_ROWS = 1'b0,
    CFG_BOARD_COLS = 1'b1
  } cfg_idx_e;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_READ_WAIT,
    ST_TICK_LOAD,
    ST_TICK_READ,
    ST_TICK_ROW
  } state_e;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_WRITE,
    OP_RESULT,
    OP_READ_ISSUE,
    OP_READ_DONE,
    OP_TICK_FIRST,
    OP_TICK_LOAD,
    OP_TICK_READ,
    OP_TICK_ROW
  } dp_op_e;

  // controller to datapath
  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             in_range;
    logic             rows_zero;
    logic             tick_last;
    logic             clear_last;
  } status_t;

endpackage

>>> rtl/life_automaton_generation.sv
// ----------------------------------------------------------------------------
// life_automaton_generation
// cell board under the B3/S23 rule with cell write, cell read and tick
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a clock edge with start_i high and busy_o low:
//   req_type_i selects write cell, read cell or one generation tick.
//   Every request gives one result on read_value_o / out_of_range_o, shown
//   for exactly one cycle with result_strobe_o high; the receiver cannot
//   stall it. busy_o drops with the strobe, so the next request can be
//   taken in the cycle the result is shown.
//   Write, unknown code, out-of-range access and a tick on an empty board
//   answer straight from the decode state; an in-range read first waits
//   for the registered memory read. A tick loads the first row, then
//   for each row reads the row below and writes the new row, one after
//   the other in the row memory.
//   board_rows / board_cols are written on the cfg channel (index 0 rows,
//   1 cols), which is always ready; write them only while idle.
//   After reset the board is cleared one row per cycle, all 64 rows, with
//   busy_o high; configuration writes are taken meanwhile.
// ----------------------------------------------------------------------------
module life_automaton_generation (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [lag_pkg::REQ_W-1:0]   req_type_i,
  input  logic [lag_pkg::COORD_W-1:0] cell_x_i,
  input  logic [lag_pkg::COORD_W-1:0] cell_y_i,
  input  logic                        cell_value_i,
  output logic                        result_strobe_o,
  output logic                        read_value_o,
  output logic                        out_of_range_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lag_pkg::CFG_IW-1:0]  cfg_index_i,
  input  logic [lag_pkg::CFG_W-1:0]   cfg_data_i
);
  import lag_pkg::*;

  cmd_t    cmd;
  status_t status;

  // configuration registers accept at any time
  assign cfg_ready_o = 1'b1;

  // sequencer
  lag_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // board storage and generation logic
  lag_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .req_type_i      (req_type_i),
    .cell_x_i        (cell_x_i),
    .cell_y_i        (cell_y_i),
    .cell_value_i    (cell_value_i),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .result_strobe_o (result_strobe_o),
    .read_value_o    (read_value_o),
    .out_of_range_o  (out_of_range_o)
  );

endmodule

>>> rtl/lag_ctrl.sv
// ----------------------------------------------------------------------------
// lag_ctrl
// sequencer for clear pass, cell access and generation ticks
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lag_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  lag_pkg::status_t status_i,
  output lag_pkg::cmd_t    cmd_o
);
  import lag_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and datapath command
  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.op = OP_ACCEPT;
          state_d  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (status_i.req_type)
          REQ_WRITE: begin
            cmd_o.op = OP_WRITE;
            state_d  = ST_IDLE;
          end
          REQ_READ: begin
            if (status_i.in_range) begin
              cmd_o.op = OP_READ_ISSUE;
              state_d  = ST_READ_WAIT;
            end else begin
              cmd_o.op = OP_RESULT;
              state_d  = ST_IDLE;
            end
          end
          REQ_TICK: begin
            if (status_i.rows_zero) begin
              cmd_o.op = OP_RESULT;
              state_d  = ST_IDLE;
            end else begin
              cmd_o.op = OP_TICK_FIRST;
              state_d  = ST_TICK_LOAD;
            end
          end
          default: begin
            cmd_o.op = OP_RESULT;
            state_d  = ST_IDLE;
          end
        endcase
      end
      ST_READ_WAIT: begin
        cmd_o.op = OP_READ_DONE;
        state_d  = ST_IDLE;
      end
      ST_TICK_LOAD: begin
        cmd_o.op = OP_TICK_LOAD;
        state_d  = ST_TICK_READ;
      end
      ST_TICK_READ: begin
        cmd_o.op = OP_TICK_READ;
        state_d  = ST_TICK_ROW;
      end
      ST_TICK_ROW: begin
        cmd_o.op = OP_TICK_ROW;
        state_d  = status_i.tick_last ? ST_IDLE : ST_TICK_READ;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  // accepted request is always decoded next
  `LAG_ASSERT(a_accept_decode, clk_i, rst_ni, (start_i && !busy_o) |=> (state_q == ST_DECODE), "accepted request not decoded")
  // row loop continues until the last row
  `LAG_ASSERT(a_tick_loop, clk_i, rst_ni, (state_q == ST_TICK_ROW && !status_i.tick_last) |=> (state_q == ST_TICK_READ), "tick row loop left early")

endmodule

>>> rtl/lag_datapath.sv
// ----------------------------------------------------------------------------
// lag_datapath
// row-wide cell memory, row buffers, next generation logic and results
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lag_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lag_pkg::cmd_t                   cmd_i,
  output lag_pkg::status_t                status_o,
  input  logic [lag_pkg::REQ_W-1:0]       req_type_i,
  input  logic [lag_pkg::COORD_W-1:0]     cell_x_i,
  input  logic [lag_pkg::COORD_W-1:0]     cell_y_i,
  input  logic                            cell_value_i,
  input  logic                            cfg_we_i,
  input  logic [lag_pkg::CFG_IW-1:0]      cfg_index_i,
  input  logic [lag_pkg::CFG_W-1:0]       cfg_data_i,
  output logic                            result_strobe_o,
  output logic                            read_value_o,
  output logic                            out_of_range_o
);
  import lag_pkg::*;

  // board memory, one row of cells per word
  logic [MAX_COLS-1:0] mem_q [MAX_ROWS];
  logic [MAX_COLS-1:0] rdata_q;
  logic                mem_we, mem_re;
  logic [ROW_AW-1:0]   mem_waddr, mem_raddr;
  logic [MAX_COLS-1:0] mem_wdata, mem_wmask;

  // configuration
  logic [CFG_W-1:0] rows_cfg_q, cols_cfg_q;
  logic [DIM_W-1:0] rows_eff, cols_eff;

  // latched request
  logic [REQ_W-1:0]   req_q;
  logic [COORD_W-1:0] x_q, y_q_in;
  logic               val_q;

  // tick state
  logic [ROW_AW-1:0]   y_q, y_d;
  logic [MAX_COLS-1:0] prior_q, prior_d, cur_q, cur_d;
  logic [MAX_COLS-1:0] col_mask, below, new_row, nxt;
  logic [MAX_COLS+1:0] pad_p, pad_c, pad_b;
  logic [3:0]          live [MAX_COLS];

  // result
  logic strobe_q, strobe_d, rval_q, rval_d, oor_q, oor_d;

  logic in_range, rw_req, has_below, tick_last;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= ROWS_RESET;
      cols_cfg_q <= COLS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BOARD_ROWS: rows_cfg_q <= cfg_data_i;
        CFG_BOARD_COLS: cols_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // dimensions clamped to the board size
  always_comb begin
    rows_eff = (DIM_W'(rows_cfg_q) > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS)
                                                       : DIM_W'(rows_cfg_q);
    cols_eff = (DIM_W'(cols_cfg_q) > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS)
                                                       : DIM_W'(cols_cfg_q);
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_ACCEPT) begin
      req_q  <= req_type_i;
      x_q    <= cell_x_i;
      y_q_in <= cell_y_i;
      val_q  <= cell_value_i;
    end
  end

  // status toward the controller
  assign in_range  = (DIM_W'(x_q) < cols_eff) && (DIM_W'(y_q_in) < rows_eff);
  assign rw_req    = (req_q == REQ_WRITE) || (req_q == REQ_READ);
  assign has_below = (DIM_W'(y_q) + DIM_W'(1)) < rows_eff;
  assign tick_last = (DIM_W'(y_q) == (rows_eff - DIM_W'(1)));

  always_comb begin
    status_o.req_type   = req_q;
    status_o.in_range   = in_range;
    status_o.rows_zero  = (rows_eff == '0);
    status_o.tick_last  = tick_last;
    status_o.clear_last = (y_q == ROW_AW'(MAX_ROWS - 1));
  end

  // columns in use; cells beyond them count as dead and stay untouched
  always_comb begin
    for (int i = 0; i < MAX_COLS; i++) begin
      col_mask[i] = (DIM_W'(i) < cols_eff);
    end
  end

  // next generation of one row, one lane per column
  always_comb begin
    below = has_below ? rdata_q : '0;
    pad_p = {1'b0, prior_q & col_mask, 1'b0};
    pad_c = {1'b0, cur_q & col_mask, 1'b0};
    pad_b = {1'b0, below & col_mask, 1'b0};
    for (int i = 0; i < MAX_COLS; i++) begin
      live[i] = 4'(pad_p[i]) + 4'(pad_p[i+1]) + 4'(pad_p[i+2])
              + 4'(pad_c[i]) + 4'(pad_c[i+2])
              + 4'(pad_b[i]) + 4'(pad_b[i+1]) + 4'(pad_b[i+2]);
      nxt[i]  = (live[i] == 4'd3) || (cur_q[i] && (live[i] == 4'd2));
    end
    new_row = (nxt & col_mask) | (cur_q & ~col_mask);
  end

  // operation decode
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = y_q;
    mem_raddr = y_q + ROW_AW'(1);
    mem_wdata = '0;
    mem_wmask = '1;
    y_d       = y_q;
    prior_d   = prior_q;
    cur_d     = cur_q;
    strobe_d  = 1'b0;
    rval_d    = rval_q;
    oor_d     = oor_q;
    case (cmd_i.op)
      OP_CLEAR: begin
        mem_we = 1'b1;
        y_d    = y_q + ROW_AW'(1);
      end
      OP_WRITE: begin
        mem_we    = in_range;
        mem_waddr = ROW_AW'(y_q_in);
        mem_wdata = {MAX_COLS{val_q}};
        mem_wmask = '0;
        mem_wmask[COL_AW'(x_q)] = 1'b1;
        strobe_d  = 1'b1;
        rval_d    = 1'b0;
        oor_d     = !in_range;
      end
      OP_RESULT: begin
        strobe_d = 1'b1;
        rval_d   = 1'b0;
        oor_d    = rw_req && !in_range;
      end
      OP_READ_ISSUE: begin
        mem_re    = 1'b1;
        mem_raddr = ROW_AW'(y_q_in);
      end
      OP_READ_DONE: begin
        strobe_d = 1'b1;
        rval_d   = rdata_q[COL_AW'(x_q)];
        oor_d    = 1'b0;
      end
      OP_TICK_FIRST: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        y_d       = '0;
      end
      OP_TICK_LOAD: begin
        cur_d   = rdata_q;
        prior_d = '0;
      end
      OP_TICK_READ: begin
        mem_re = 1'b1;
      end
      OP_TICK_ROW: begin
        mem_we    = 1'b1;
        mem_wdata = new_row;
        prior_d   = cur_q;
        cur_d     = below;
        y_d       = y_q + ROW_AW'(1);
        if (tick_last) begin
          strobe_d = 1'b1;
          rval_d   = 1'b0;
          oor_d    = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // cell memory with per-cell write enables and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      for (int i = 0; i < MAX_COLS; i++) begin
        if (mem_wmask[i]) begin
          mem_q[mem_waddr][i] <= mem_wdata[i];
        end
      end
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_q      <= '0;
      strobe_q <= 1'b0;
    end else begin
      y_q      <= y_d;
      strobe_q <= strobe_d;
    end
  end

  // row buffers and result payload
  always_ff @(posedge clk_i) begin
    prior_q <= prior_d;
    cur_q   <= cur_d;
    rval_q  <= rval_d;
    oor_q   <= oor_d;
  end

  assign result_strobe_o = strobe_q;
  assign read_value_o    = rval_q;
  assign out_of_range_o  = oor_q;

  // a result never follows another in the next cycle
  `LAG_ASSERT(a_strobe_pulse, clk_i, rst_ni, strobe_q |=> !strobe_q, "result strobe held two cycles")
  // row update stays inside the rows in use
  `LAG_ASSERT(a_row_in_board, clk_i, rst_ni, (cmd_i.op == OP_TICK_ROW) |-> (DIM_W'(y_q) < rows_eff), "tick row beyond board")
  // no generation on an empty board
  `LAG_ASSERT_NEVER(a_no_empty_tick, clk_i, rst_ni, (cmd_i.op == OP_TICK_FIRST) && (rows_eff == '0), "tick started on empty board")

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the life automaton generation block
// ----------------------------------------------------------------------------
// Drives cell write, cell read and tick requests through the start / busy
// handshake and checks every strobed result against a cycle-free board model
// kept in the bench. A short table of directed requests comes first (reset
// state, board corners, the unused request code, out-of-range coordinates,
// an empty board and oversize dimensions), then random phases, each with its
// own board size, mostly small boards so that ticks stay cheap and patterns
// stay dense.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import lag_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 112;
  localparam int PLAN_ROWS    = 28;

  // one row of the directed plan: a request or a register write
  typedef enum logic {STEP_REQ, STEP_CFG} step_e;

  typedef struct packed {
    step_e            kind;
    logic [REQ_W-1:0] req;
    logic [5:0]       x;
    logic [5:0]       y;
    logic             v;
    cfg_idx_e         idx;
    logic [CFG_W-1:0] data;
    logic             typed;
    logic             rv;
    logic             oor;
  } plan_row_t;

  typedef struct {
    int   seq;
    logic rv;
    logic oor;
  } cell_result_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                start_i         = 1'b0;
  logic                busy_o;
  logic [REQ_W-1:0]    req_type_i      = '0;
  logic [COORD_W-1:0]  cell_x_i        = '0;
  logic [COORD_W-1:0]  cell_y_i        = '0;
  logic                cell_value_i    = 1'b0;
  logic                result_strobe_o;
  logic                read_value_o;
  logic                out_of_range_o;
  logic                cfg_valid_i     = 1'b0;
  logic                cfg_ready_o;
  logic [CFG_IW-1:0]   cfg_index_i     = '0;
  logic [CFG_W-1:0]    cfg_data_i      = '0;

  // board model and its dimension registers
  bit               life_board [MAX_ROWS*MAX_COLS];
  logic [CFG_W-1:0] model_rows = ROWS_RESET;
  logic [CFG_W-1:0] model_cols = COLS_RESET;

  cell_result_t pending_results [$];
  int           request_count = 0;
  int           mismatches    = 0;
  bit           start_held    = 1'b0;

  // directed plan: typed results only where obvious
  plan_row_t dir_plan [PLAN_ROWS] = '{
    // fresh board after reset, corners, unused code, lone cells dying
    '{STEP_REQ, REQ_READ,   6'd0,  6'd0,  1'b0, CFG_BOARD_ROWS, 7'd0, 1'b1, 1'b0, 1'b0},
    '{STEP_REQ, REQ_WRITE,  6'd63, 6'd63, 1'b1, CFG_BOARD_ROWS, 7'd0, 1'b1, 1'b0, 1'b0},
    '{STEP_REQ, REQ_READ,   6'd63, 6'd63, 1'b0, CFG_BOARD_ROWS, 7'd0, 1'b1, 1'b1, 1'b0},
    '{STEP_REQ, REQ_WRITE,  6'd0,  6'd0,  1'b1, CFG_BOARD_ROWS, 7'd0, 1'b1, 1'b0, 1'b0},
    '{STEP_REQ, REQ_UNUSED, 6'd63, 6'd63, 1'b1, CFG_BOARD_ROWS, 7'd0, 1'b1, 1'b0, 1'b0},
    '{STEP_REQ, REQ_TICK,   6'd0,  6'd0,  1'b0, CFG_BOARD_ROWS, 7'd0, 1'b1, 1'b0, 1'b0},
    '{STEP_REQ, REQ_READ,   6'd63, 6'd63, 1'b0, CFG_BOARD_ROWS, 7'd0, 1'b1, 1'b0, 1'b0},
    // vertical blinker at the top edge
    '{STEP_REQ, REQ_WRITE,  6'd1,  6'd0,  1'b1, CFG_BOARD_ROWS, 7'd0, 1'b0, 1'b0, 1'b0},
    '{STEP_REQ, REQ_WRITE,  6'd1,  6'd1,  1'b1, CFG_BOARD_ROWS, 7'd0, 1'b0, 1'b0, 1'b0},
    '{STEP_REQ, REQ_WRITE,  6'd1,  6'd2,  1'b1, CFG_BOARD_ROWS, 7'd0, 1'b0, 1'b0, 1'b0},
    '{STEP_REQ, REQ_TICK,   6'd0,  6'd0,  1'b0, CFG_BOARD_ROWS, 7'd0, 1'b0, 1'b0, 1'b0},
    '{STEP_REQ, REQ_READ,   6'd0,  6'd1,  1'b0, CFG_BOARD_ROWS, 7'd0, 1'b0, 1'b0, 1'b0},
    // 3 x 5 board: coordinates just outside, cells beyond left alone
    '{STEP_CFG, REQ_WRITE,  6'd0,  6'd0,  1'b0, CFG_BOARD_ROWS, 7'd3, 1'b0, 1'b0, 1'b0},
    '{STEP_CFG, REQ_WRITE,  6'd0,  6'd0,  1'b0, CFG_BOARD_COLS, 7'd5, 1'b0, 1'b0, 1'b0},
    '{STEP_REQ, REQ_WRITE,  6'd5,  6'd0,  1'b1, CFG_BOARD_ROWS, 7'd0, 1'b1, 1'b0, 1'b1},
    '{STEP_REQ, REQ_READ,   6'd0,  6'd3,  1'b0, CFG_BOARD_ROWS, 7'd0, 1'b1, 1'b0, 1'b1},
    '{STEP_REQ, REQ_READ,   6'd63, 6'd63, 1'b1, CFG_BOARD_ROWS, 7'd0, 1'b1, 1'b0, 1'b1},
    '{STEP_REQ, REQ_TICK,   6'd0,  6'd0,  1'b0, CFG_BOARD_ROWS, 7'd0, 1'b0, 1'b0, 1'b0},
    '{STEP_REQ, REQ_READ,   6'd1,  6'd1,  1'b0, CFG_BOARD_ROWS, 7'd0, 1'b0, 1'b0, 1'b0},
    // empty board: everything out of range, tick does nothing
    '{STEP_CFG, REQ_WRITE,  6'd0,  6'd0,  1'b0, CFG_BOARD_ROWS, 7'd0, 1'b0, 1'b0, 1'b0},
    '{STEP_REQ, REQ_READ,   6'd0,  6'd0,  1'b0, CFG_BOARD_ROWS, 7'd0, 1'b1, 1'b0, 1'b1},
    '{STEP_REQ, REQ_WRITE,  6'd0,  6'd0,  1'b1, CFG_BOARD_ROWS, 7'd0, 1'b1, 1'b0, 1'b1},
    '{STEP_REQ, REQ_TICK,   6'd0,  6'd0,  1'b0, CFG_BOARD_ROWS, 7'd0, 1'b1, 1'b0, 1'b0},
    // dimensions above the maximum clamp to the full board
    '{STEP_CFG, REQ_WRITE,  6'd0,  6'd0,  1'b0, CFG_BOARD_ROWS, 7'd127, 1'b0, 1'b0, 1'b0},
    '{STEP_CFG, REQ_WRITE,  6'd0,  6'd0,  1'b0, CFG_BOARD_COLS, 7'd127, 1'b0, 1'b0, 1'b0},
    '{STEP_REQ, REQ_READ,   6'd63, 6'd63, 1'b0, CFG_BOARD_ROWS, 7'd0, 1'b0, 1'b0, 1'b0},
    '{STEP_REQ, REQ_WRITE,  6'd63, 6'd0,  1'b1, CFG_BOARD_ROWS, 7'd0, 1'b0, 1'b0, 1'b0},
    '{STEP_REQ, REQ_TICK,   6'd0,  6'd0,  1'b0, CFG_BOARD_ROWS, 7'd0, 1'b0, 1'b0, 1'b0}
  };

  life_automaton_generation uut (.*);

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // dimensions in play, clamped to the board
  function automatic int rows_in_play();
    return (model_rows > MAX_ROWS) ? MAX_ROWS : int'(model_rows);
  endfunction

  function automatic int cols_in_play();
    return (model_cols > MAX_COLS) ? MAX_COLS : int'(model_cols);
  endfunction

  // one generation under B3/S23, neighbours from the old board only
  task automatic advance_generation();
    bit old_board [MAX_ROWS*MAX_COLS];
    int nr;
    int nc;
    int live;
    int yy;
    int xx;
    nr = rows_in_play();
    nc = cols_in_play();
    old_board = life_board;
    for (int y = 0; y < nr; y++) begin
      for (int x = 0; x < nc; x++) begin
        live = 0;
        for (int dy = -1; dy <= 1; dy++) begin
          for (int dx = -1; dx <= 1; dx++) begin
            yy = y + dy;
            xx = x + dx;
            if ((dy != 0 || dx != 0) && yy >= 0 && yy < nr && xx >= 0 && xx < nc)
              live += old_board[yy*MAX_COLS + xx];
          end
        end
        if (old_board[y*MAX_COLS + x])
          life_board[y*MAX_COLS + x] = (live == 2 || live == 3);
        else
          life_board[y*MAX_COLS + x] = (live == 3);
      end
    end
  endtask

  // apply one request to the model and work out its result
  task automatic predict_request(input logic [REQ_W-1:0] req, input logic [5:0] x,
                                 input logic [5:0] y, input logic v,
                                 output logic rv, output logic oor);
    int pos;
    rv  = 1'b0;
    oor = 1'b0;
    pos = int'(y)*MAX_COLS + int'(x);
    if (req == REQ_WRITE || req == REQ_READ) begin
      if (int'(x) >= cols_in_play() || int'(y) >= rows_in_play())
        oor = 1'b1;
      else if (req == REQ_WRITE)
        life_board[pos] = v;
      else
        rv = life_board[pos];
    end else if (req == REQ_TICK) begin
      advance_generation();
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t ns mismatch: %s", $time, what);
    mismatches++;
  endtask

  // idle gap: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5)
      return 0;
    else if (r < 9)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // board dimension: mostly small, sometimes zero, full or oversize
  function automatic logic [CFG_W-1:0] pick_dimension();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2)
      return '0;
    else if (r < 4)
      return CFG_W'($urandom_range(MAX_ROWS + 1, 127));
    else if (r < 6)
      return CFG_W'(MAX_ROWS);
    return CFG_W'($urandom_range(1, 8));
  endfunction

  task automatic release_start();
    if (start_held) begin
      start_i    <= 1'b0;
      start_held  = 1'b0;
    end
  endtask

  // stop sending and wait until every result is back
  task automatic settle_block();
    release_start();
    while (pending_results.size() != 0)
      @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // register write over the cfg channel
  task automatic write_register(input cfg_idx_e idx, input logic [CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    if (idx == CFG_BOARD_ROWS)
      model_rows = data;
    else
      model_cols = data;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // send one request, predict its result, then idle for gap cycles
  task automatic issue_request(input logic [REQ_W-1:0] req, input logic [5:0] x,
                               input logic [5:0] y, input logic v, input logic typed,
                               input logic typed_rv, input logic typed_oor,
                               input int gap);
    cell_result_t want;
    start_i      <= 1'b1;
    start_held    = 1'b1;
    req_type_i   <= req;
    cell_x_i     <= x;
    cell_y_i     <= y;
    cell_value_i <= v;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    predict_request(req, x, y, v, want.rv, want.oor);
    if (typed) begin
      want.rv  = typed_rv;
      want.oor = typed_oor;
    end
    want.seq = request_count;
    request_count++;
    pending_results.push_back(want);
    if (gap > 0) begin
      release_start();
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // result check against the oldest outstanding request
  always @(posedge clk_i) begin : result_check
    cell_result_t want;
    if (rst_ni && result_strobe_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result strobe with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        if (read_value_o !== want.rv)
          report_mismatch($sformatf("request %0d read_value %b, expected %b",
                                    want.seq, read_value_o, want.rv));
        if (out_of_range_o !== want.oor)
          report_mismatch($sformatf("request %0d out_of_range %b, expected %b",
                                    want.seq, out_of_range_o, want.oor));
      end
    end
  end

  // stimulus
  initial begin : stimulus
    logic [REQ_W-1:0] req;
    logic [5:0]       x;
    logic [5:0]       y;
    logic             v;
    int               sel;
    int               sent;
    int               phase_len;
    bit               no_gaps;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed plan
    foreach (dir_plan[i]) begin
      if (dir_plan[i].kind == STEP_CFG) begin
        settle_block();
        write_register(dir_plan[i].idx, dir_plan[i].data);
      end else begin
        issue_request(dir_plan[i].req, dir_plan[i].x, dir_plan[i].y, dir_plan[i].v,
                      dir_plan[i].typed, dir_plan[i].rv, dir_plan[i].oor, pick_gap());
      end
    end

    // random phases, one board size each
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle_block();
      write_register(CFG_BOARD_ROWS, pick_dimension());
      write_register(CFG_BOARD_COLS, pick_dimension());
      no_gaps   = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(8, 24);
      repeat (phase_len) begin
        sel = $urandom_range(0, 99);
        x   = 6'($urandom_range(0, 63));
        y   = 6'($urandom_range(0, 63));
        v   = ($urandom_range(0, 2) != 0);
        // mostly coordinates on the board, some anywhere
        if (rows_in_play() > 0 && cols_in_play() > 0 && $urandom_range(0, 9) != 0) begin
          x = 6'($urandom_range(0, cols_in_play() - 1));
          y = 6'($urandom_range(0, rows_in_play() - 1));
        end
        if (sel < 45)
          req = REQ_WRITE;
        else if (sel < 75)
          req = REQ_READ;
        else if (sel < 93)
          req = REQ_TICK;
        else
          req = REQ_UNUSED;
        issue_request(req, x, y, v, 1'b0, 1'b0, 1'b0, no_gaps ? 0 : pick_gap());
        sent++;
        if ($urandom_range(0, 19) == 0)
          settle_block();
      end
    end

    settle_block();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
